>>> rtl/rrca_pkg.sv
// Package for the reorder receiver with cumulative acknowledgement.
// Holds field widths, result kind codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package rrca_pkg;

    localparam int SEQ_W            = 31;
    localparam int SIZE_W           = 11;
    localparam int KIND_W           = 3;
    localparam int SLOT_W           = 4;
    localparam int DEF_WINDOW_SLOTS = 10;

    localparam logic [SIZE_W-1:0] MAX_PAYLOAD = 11'd1456;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVER = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_END     = 3'd2,
        KIND_DROP    = 3'd3,
        KIND_REJECT  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACK_MID,
        ST_DRAIN,
        ST_ACK_END
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REJECT,
        OP_END,
        OP_DELIVER,
        OP_ACK,
        OP_STORE,
        OP_DROP,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic in_order;
        logic size_zero;
        logic later;
        logic dup;
        logic full;
        logic any_valid;
        logic hit;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/reorder_receiver_cumulative_ack.sv
// On start the header is loaded and the evaluate state entered; the first result of the segment
// is registered from that state. A dropped segment or a nonempty in-order one gives further results,
// and stored segments that then continue the stream are drained, one per cycle. The drain loop
// over the slot table sets the longest case. A new segment is taken only while busy is low.
// Results go out as one-cycle strobes; the receiver cannot stall them.
// Synchronous active-low reset clears the expected byte, the end flag and all slot valid bits.
`default_nettype none

module reorder_receiver_cumulative_ack #(
    parameter int WINDOW_SLOTS = rrca_pkg::DEF_WINDOW_SLOTS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [rrca_pkg::SEQ_W-1:0]   i_seg_seqno,
    input  wire  [rrca_pkg::SIZE_W-1:0]  i_seg_size,
    output logic                         o_strobe,
    output logic [rrca_pkg::KIND_W-1:0]  o_kind,
    output logic [rrca_pkg::SEQ_W-1:0]   o_out_seqno,
    output logic [rrca_pkg::SIZE_W-1:0]  o_out_size,
    output logic                         o_from_store,
    output logic [rrca_pkg::SLOT_W-1:0]  o_slot_index,
    output logic [rrca_pkg::SEQ_W-1:0]   o_ack_number,
    output logic                         o_last
);
    import rrca_pkg::*;

    t_cmd    cmd;
    t_status status;

    rrca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    rrca_datapath #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg_seqno  (i_seg_seqno),
        .i_seg_size   (i_seg_size),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_out_seqno  (o_out_seqno),
        .o_out_size   (o_out_size),
        .o_from_store (o_from_store),
        .o_slot_index (o_slot_index),
        .o_ack_number (o_ack_number),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

>>> rtl/rrca_ctrl.sv
// Controller state machine for the reorder receiver.
// Sequences one segment header into result commands for rrca_datapath; uses rrca_pkg.
`default_nettype none

module rrca_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  rrca_pkg::t_status i_status,
    output rrca_pkg::t_cmd   o_cmd,
    output logic             busy
);
    import rrca_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.reject) begin
                    n_state = ST_IDLE;
                end else if (i_status.in_order) begin
                    n_state = i_status.size_zero ? ST_IDLE : ST_ACK_MID;
                end else if (i_status.later && !i_status.dup && i_status.full) begin
                    n_state = ST_ACK_END;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACK_MID: begin
                n_state = i_status.any_valid ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                n_state = i_status.hit ? ST_DRAIN : ST_IDLE;
            end
            ST_ACK_END: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.op = start ? OP_LOAD : OP_NONE;
            end
            ST_EVAL: begin
                if (i_status.reject) begin
                    o_cmd.op   = OP_REJECT;
                    o_cmd.last = 1'b1;
                end else if (i_status.in_order) begin
                    if (i_status.size_zero) begin
                        o_cmd.op   = OP_END;
                        o_cmd.last = 1'b1;
                    end else begin
                        o_cmd.op = OP_DELIVER;
                    end
                end else if (i_status.later) begin
                    if (i_status.dup) begin
                        o_cmd.op   = OP_ACK;
                        o_cmd.last = 1'b1;
                    end else if (i_status.full) begin
                        o_cmd.op = OP_DROP;
                    end else begin
                        o_cmd.op   = OP_STORE;
                        o_cmd.last = 1'b1;
                    end
                end else begin
                    o_cmd.op   = OP_ACK;
                    o_cmd.last = 1'b1;
                end
            end
            ST_ACK_MID: begin
                o_cmd.op   = OP_ACK;
                o_cmd.last = !i_status.any_valid;
            end
            ST_DRAIN: begin
                if (i_status.hit) begin
                    o_cmd.op = OP_POP;
                end else begin
                    o_cmd.op   = OP_ACK;
                    o_cmd.last = 1'b1;
                end
            end
            ST_ACK_END: begin
                o_cmd.op   = OP_ACK;
                o_cmd.last = 1'b1;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/rrca_datapath.sv
// Datapath of the reorder receiver: expected byte, end flag, slot table and result register.
// Executes commands from rrca_ctrl and reports status back; uses rrca_pkg.
`default_nettype none

module rrca_datapath #(
    parameter int WINDOW_SLOTS = rrca_pkg::DEF_WINDOW_SLOTS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [rrca_pkg::SEQ_W-1:0]   i_seg_seqno,
    input  wire  [rrca_pkg::SIZE_W-1:0]  i_seg_size,
    input  rrca_pkg::t_cmd               i_cmd,
    output rrca_pkg::t_status            o_status,
    output logic                         o_strobe,
    output logic [rrca_pkg::KIND_W-1:0]  o_kind,
    output logic [rrca_pkg::SEQ_W-1:0]   o_out_seqno,
    output logic [rrca_pkg::SIZE_W-1:0]  o_out_size,
    output logic                         o_from_store,
    output logic [rrca_pkg::SLOT_W-1:0]  o_slot_index,
    output logic [rrca_pkg::SEQ_W-1:0]   o_ack_number,
    output logic                         o_last
);
    import rrca_pkg::*;

    localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    logic [SEQ_W-1:0]        r_expected;
    logic                    r_ended;
    logic [WINDOW_SLOTS-1:0] r_slot_valid;
    logic [SEQ_W-1:0]        r_slot_seq  [WINDOW_SLOTS];
    logic [SIZE_W-1:0]       r_slot_size [WINDOW_SLOTS];
    logic [SEQ_W-1:0]        r_seq;
    logic [SIZE_W-1:0]       r_size;

    logic                    r_strobe;
    t_kind                   r_kind;
    logic [SEQ_W-1:0]        r_out_seqno;
    logic [SIZE_W-1:0]       r_out_size;
    logic                    r_from_store;
    logic [SLOT_W-1:0]       r_slot_index;
    logic [SEQ_W-1:0]        r_ack_number;
    logic                    r_last;

    t_kind                   n_kind;
    logic [SEQ_W-1:0]        n_out_seqno;
    logic [SIZE_W-1:0]       n_out_size;
    logic                    n_from_store;
    logic [SLOT_W-1:0]       n_slot_index;
    logic [SEQ_W-1:0]        n_ack_number;
    logic [SEQ_W-1:0]        n_expected;

    logic                    hit;
    logic [IW-1:0]           hit_idx;
    logic                    free_found;
    logic [IW-1:0]           free_idx;
    logic                    dup;
    logic [SIZE_W-1:0]       hit_size;

    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        dup        = 1'b0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_valid[i] && (r_slot_seq[i] == r_expected)) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!r_slot_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
            if (r_slot_valid[i] && (r_slot_seq[i] == r_seq)) begin
                dup = 1'b1;
            end
        end
    end

    assign hit_size = r_slot_size[hit_idx];

    always_comb begin
        o_status.reject    = r_ended || (r_size > MAX_PAYLOAD);
        o_status.in_order  = (r_seq == r_expected);
        o_status.size_zero = (r_size == '0);
        o_status.later     = (r_seq > r_expected);
        o_status.dup       = dup;
        o_status.full      = !free_found;
        o_status.any_valid = |r_slot_valid;
        o_status.hit       = hit;
    end

    always_comb begin
        n_kind       = KIND_ACK;
        n_out_seqno  = '0;
        n_out_size   = '0;
        n_from_store = 1'b0;
        n_slot_index = '0;
        n_ack_number = '0;
        n_expected   = r_expected;
        case (i_cmd.op)
            OP_REJECT: begin
                n_kind = KIND_REJECT;
            end
            OP_END: begin
                n_kind = KIND_END;
            end
            OP_DELIVER: begin
                n_kind      = KIND_DELIVER;
                n_out_seqno = r_seq;
                n_out_size  = r_size;
                n_expected  = r_expected + SEQ_W'(r_size);
            end
            OP_ACK: begin
                n_kind       = KIND_ACK;
                n_ack_number = r_expected;
            end
            OP_STORE: begin
                n_kind       = KIND_ACK;
                n_out_seqno  = r_seq;
                n_slot_index = SLOT_W'(free_idx);
                n_ack_number = r_expected;
            end
            OP_DROP: begin
                n_kind      = KIND_DROP;
                n_out_seqno = r_seq;
            end
            OP_POP: begin
                n_kind       = KIND_DELIVER;
                n_out_seqno  = r_expected;
                n_out_size   = hit_size;
                n_from_store = 1'b1;
                n_slot_index = SLOT_W'(hit_idx);
                n_expected   = r_expected + SEQ_W'(hit_size);
            end
            default: begin
                n_kind = KIND_ACK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= '0;
            r_ended      <= 1'b0;
            r_slot_valid <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_expected <= n_expected;
            r_strobe   <= (i_cmd.op != OP_NONE) && (i_cmd.op != OP_LOAD);
            if (i_cmd.op == OP_END) begin
                r_ended <= 1'b1;
            end
            if (i_cmd.op == OP_STORE) begin
                r_slot_valid[free_idx] <= 1'b1;
            end
            if (i_cmd.op == OP_POP) begin
                r_slot_valid[hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_seq  <= i_seg_seqno;
            r_size <= i_seg_size;
        end
        if (i_cmd.op == OP_STORE) begin
            r_slot_seq[free_idx]  <= r_seq;
            r_slot_size[free_idx] <= r_size;
        end
        r_kind       <= n_kind;
        r_out_seqno  <= n_out_seqno;
        r_out_size   <= n_out_size;
        r_from_store <= n_from_store;
        r_slot_index <= n_slot_index;
        r_ack_number <= n_ack_number;
        r_last       <= i_cmd.last;
    end

    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_out_seqno  = r_out_seqno;
    assign o_out_size   = r_out_size;
    assign o_from_store = r_from_store;
    assign o_slot_index = r_slot_index;
    assign o_ack_number = r_ack_number;
    assign o_last       = r_last;

endmodule

`default_nettype wire

>>> rtl/rrca_checker.sv
// Port-level checker for the reorder receiver, with its bind to the top level.
// Watches the start/busy handshake and the result strobe; uses rrca_pkg.
`default_nettype none

module rrca_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          start,
    input wire                          busy,
    input wire                          o_strobe,
    input wire [rrca_pkg::KIND_W-1:0]   o_kind,
    input wire                          o_last
);
    import rrca_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted beat");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result strobe in the cycle after an accepted beat");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("block idle while results of a beat are still pending");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("block still busy while the final result is shown");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_kind == KIND_REJECT) || (o_kind == KIND_END))) |-> o_last)
        else $error("reject or end of stream result not marked last");

endmodule

bind reorder_receiver_cumulative_ack rrca_checker u_rrca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_kind   (o_kind),
    .o_last   (o_last)
);

`default_nettype wire
